/* hdl/banker_request_safety_check_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the banker request safety check block
// Concurrent checks written as one-line macro uses in the RTL.
// ----------------------------------------------------------------------------
`ifndef BANKER_REQUEST_SAFETY_CHECK_TOP_ASSERT_SVH
`define BANKER_REQUEST_SAFETY_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define BRSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BRSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/brsc_pkg.sv */
// ----------------------------------------------------------------------------
// brsc_pkg
// Shared types and codes of the banker request safety check block.
// ----------------------------------------------------------------------------
`default_nettype none

package brsc_pkg;

   localparam logic [1:0] REQ_LOAD_ALLOC = 2'd0;
   localparam logic [1:0] REQ_LOAD_MAX   = 2'd1;
   localparam logic [1:0] REQ_LOAD_AVAIL = 2'd2;
   localparam logic [1:0] REQ_REQUEST    = 2'd3;

   localparam logic [1:0] STATUS_GRANT   = 2'd0;
   localparam logic [1:0] STATUS_UNSAFE  = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic CSR_ACTIVE_PROCS = 1'b0;
   localparam logic CSR_ACTIVE_RES   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_alloc;
      logic load_max;
      logic load_avail;
      logic apply;
      logic rollback;
      logic add_work;
   } lane_cmd_type;

   typedef struct packed {
      logic bad;
      logic fits;
   } lane_flag_type;

   typedef struct packed {
      logic any_bad;
      logic all_fit;
   } check_type;

endpackage

`default_nettype wire

/* hdl/brsc_lane.sv */
// ----------------------------------------------------------------------------
// brsc_lane
// One resource lane: allocation and maximum columns, available and work
// counts, and the per-lane request and fit tests.
// ----------------------------------------------------------------------------
`default_nettype none

module brsc_lane #(
   parameter int MAX_PROCS = 16,
   parameter int UNIT_BITS = 8,
   parameter int WORK_W    = 15
) (
   input  wire                                   clock,
   input  wire brsc_pkg::lane_cmd_type           cmd,
   input  wire  [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] wr_addr,
   input  wire  [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] rd_addr,
   input  wire  [UNIT_BITS-1:0]                  load_data,
   input  wire  [UNIT_BITS-1:0]                  amount,
   input  wire                                   active,
   output brsc_pkg::lane_flag_type               flags
);

   logic [UNIT_BITS-1:0] alloc_mem [MAX_PROCS];
   logic [UNIT_BITS-1:0] max_mem   [MAX_PROCS];

   logic [UNIT_BITS-1:0] alloc_rd_ff;
   logic [UNIT_BITS-1:0] max_rd_ff;
   logic [UNIT_BITS-1:0] orig_ff;
   logic [UNIT_BITS-1:0] avail_ff, avail_in;
   logic [WORK_W-1:0]    work_ff, work_in;
   logic signed [UNIT_BITS:0] need;
   logic                 over_need;
   logic                 over_avail;

   always_ff @(posedge clock) begin
      if (cmd.load_alloc) begin
         alloc_mem[wr_addr] <= load_data;
      end else if (cmd.apply && active) begin
         alloc_mem[wr_addr] <= alloc_rd_ff + amount;
      end else if (cmd.rollback && active) begin
         alloc_mem[wr_addr] <= orig_ff;
      end
      if (cmd.load_max) begin
         max_mem[wr_addr] <= load_data;
      end
      alloc_rd_ff <= alloc_mem[rd_addr];
      max_rd_ff   <= max_mem[rd_addr];
   end

   always_comb begin
      avail_in = avail_ff;
      if (cmd.load_avail) begin
         avail_in = load_data;
      end else if (cmd.apply && active) begin
         avail_in = avail_ff - amount;
      end else if (cmd.rollback && active) begin
         avail_in = avail_ff + amount;
      end
   end

   always_comb begin
      work_in = work_ff;
      if (cmd.apply) begin
         work_in = WORK_W'(avail_ff - amount);
      end else if (cmd.add_work) begin
         work_in = work_ff + WORK_W'(alloc_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      avail_ff <= avail_in;
      work_ff  <= work_in;
      if (cmd.apply) begin
         orig_ff <= alloc_rd_ff;
      end
   end

   always_comb begin
      need       = $signed({1'b0, max_rd_ff}) - $signed({1'b0, alloc_rd_ff});
      over_need  = $signed({1'b0, amount}) > need;
      over_avail = amount > avail_ff;
      flags.bad  = active & (over_need | over_avail);
      flags.fits = !active || need[UNIT_BITS] || (need == '0) ||
                   (WORK_W'(need[UNIT_BITS-1:0]) <= work_ff);
   end

endmodule

`default_nettype wire

/* hdl/brsc_merge.sv */
// ----------------------------------------------------------------------------
// brsc_merge
// Combine the lane flags: a request is bad if any lane objects, a process
// fits if every lane agrees.
// ----------------------------------------------------------------------------
`default_nettype none

module brsc_merge #(
   parameter int LANES = 4
) (
   input  brsc_pkg::lane_flag_type flags [LANES],
   output brsc_pkg::check_type     check
);

   always_comb begin
      check.any_bad = 1'b0;
      check.all_fit = 1'b1;
      for (int j = 0; j < LANES; j++) begin
         check.any_bad = check.any_bad | flags[j].bad;
         check.all_fit = check.all_fit & flags[j].fits;
      end
   end

endmodule

`default_nettype wire

/* hdl/banker_request_safety_check_top.sv */
// ----------------------------------------------------------------------------
// banker_request_safety_check_top
// Banker's deadlock-avoidance unit with one lane per resource type.
// ----------------------------------------------------------------------------
// Use: beats arrive on the req_ channel (valid/stall). Load beats write an
// allocation row, a maximum row or the available vector and give no result.
// A request beat is checked against need and available once its rows are
// read; an invalid one gives a single rsp_ beat with status 2. A valid one
// is applied and a safety check streams the processes through the lane
// column memories at one process per cycle, one registered read port each:
// at most n passes run (n active processes). A safe request gives n beats
// carrying the safe sequence; an unsafe one is rolled back and gives one
// beat with status 1. rsp_last marks the final beat of a request. One
// request is in work at a time: req_stall stays high from a request's
// acceptance until its last beat is taken, and while rsp_stall is high the
// current beat holds. Reset (synchronous, active high) returns the
// controller to idle and the registers to 16 processes and 4 resource
// types; the tables hold no defined contents until loaded. csr_ writes take
// effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module banker_request_safety_check_top #(
   parameter int MAX_PROCS = 16,
   parameter int RES_LANES = 4,
   parameter int UNIT_BITS = 8
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [1:0] req_type,
   input  wire  [3:0] req_process,
   input  wire  [7:0] req_amount_0,
   input  wire  [7:0] req_amount_1,
   input  wire  [7:0] req_amount_2,
   input  wire  [7:0] req_amount_3,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [1:0] rsp_status,
   output logic [3:0] rsp_seq_process,
   output logic       rsp_seq_valid,
   output logic       rsp_last,
   input  wire        csr_we,
   input  wire        csr_index,
   input  wire  [4:0] csr_wdata
);

`include "banker_request_safety_check_top_assert.svh"

   localparam int NUM_LANES  = RES_LANES < 4 ? RES_LANES : 4;
   localparam int PROC_LIMIT = MAX_PROCS < 16 ? MAX_PROCS : 16;
   localparam int PW         = MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1;
   localparam int SEQ_W      = PROC_LIMIT > 1 ? $clog2(PROC_LIMIT) : 1;
   localparam int CNT_W      = $clog2(PROC_LIMIT + 1);
   localparam int WORK_W     = UNIT_BITS + 7;

   brsc_pkg::state_type     state_ff, state_in;
   brsc_pkg::lane_cmd_type  cmd;
   brsc_pkg::lane_flag_type flags [NUM_LANES];
   brsc_pkg::check_type     check;

   logic [4:0]           procs_cfg_ff;
   logic [2:0]           res_cfg_ff;
   logic [4:0]           n_eff;
   logic [2:0]           r_eff;

   logic [3:0]           proc_ff, proc_in;
   logic [UNIT_BITS-1:0] amt_ff [NUM_LANES];
   logic [7:0]           amt_port [4];
   logic                 amt_latch;
   logic [PW-1:0]        scan_ff, scan_in;
   logic [PW-1:0]        eval_idx_ff, eval_idx_in;
   logic                 eval_valid_ff, eval_valid_in;
   logic [MAX_PROCS-1:0] done_ff, done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 progress_ff, progress_in;
   logic [3:0]           seq_ff [PROC_LIMIT];
   logic                 seq_we;
   logic [1:0]           status_ff, status_in;
   logic                 granted_ff, granted_in;
   logic [SEQ_W-1:0]     out_idx_ff, out_idx_in;

   logic                 req_accept;
   logic                 in_range;
   logic                 eval_fit;
   logic                 pass_end;
   logic [CNT_W-1:0]     cnt_next;
   logic                 prog_next;
   logic                 all_done;
   logic                 out_last;
   logic [PW-1:0]        rd_addr;
   logic [PW-1:0]        wr_addr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         procs_cfg_ff <= 5'd16;
         res_cfg_ff   <= 3'd4;
      end else if (csr_we) begin
         case (csr_index)
            brsc_pkg::CSR_ACTIVE_PROCS: procs_cfg_ff <= csr_wdata;
            brsc_pkg::CSR_ACTIVE_RES:   res_cfg_ff   <= csr_wdata[2:0];
            default:                    procs_cfg_ff <= procs_cfg_ff;
         endcase
      end
   end

   always_comb begin
      n_eff = procs_cfg_ff;
      if (procs_cfg_ff == 5'd0) n_eff = 5'd1;
      else if (7'(procs_cfg_ff) > 7'(PROC_LIMIT)) n_eff = 5'(PROC_LIMIT);
      r_eff = res_cfg_ff;
      if (res_cfg_ff == 3'd0) r_eff = 3'd1;
      else if (4'(res_cfg_ff) > 4'(NUM_LANES)) r_eff = 3'(NUM_LANES);
   end

   assign amt_port[0] = req_amount_0;
   assign amt_port[1] = req_amount_1;
   assign amt_port[2] = req_amount_2;
   assign amt_port[3] = req_amount_3;

   assign req_stall  = (state_ff != brsc_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign in_range   = 7'(req_process) < 7'(MAX_PROCS);

   assign eval_fit  = eval_valid_ff && !done_ff[eval_idx_ff] && check.all_fit;
   assign pass_end  = eval_valid_ff && ((7'(eval_idx_ff) + 7'd1) == 7'(n_eff));
   assign cnt_next  = count_ff + CNT_W'(eval_fit);
   assign prog_next = progress_ff | eval_fit;
   assign all_done  = 7'(cnt_next) == 7'(n_eff);
   assign out_last  = !granted_ff || ((7'(out_idx_ff) + 7'd1) == 7'(n_eff));

   assign rd_addr = (state_ff == brsc_pkg::ST_IDLE) ? PW'(req_process) : scan_ff;
   assign wr_addr = (state_ff == brsc_pkg::ST_IDLE) ? PW'(req_process) : PW'(proc_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brsc_pkg::ST_IDLE: begin
            if (req_accept && req_type == brsc_pkg::REQ_REQUEST) begin
               if (5'(req_process) >= n_eff) state_in = brsc_pkg::ST_EMIT;
               else state_in = brsc_pkg::ST_CHECK;
            end
         end
         brsc_pkg::ST_CHECK: begin
            if (check.any_bad) state_in = brsc_pkg::ST_EMIT;
            else state_in = brsc_pkg::ST_SCAN;
         end
         brsc_pkg::ST_SCAN: begin
            if (pass_end && (all_done || !prog_next)) state_in = brsc_pkg::ST_EMIT;
         end
         brsc_pkg::ST_EMIT: begin
            if (!rsp_stall && out_last) state_in = brsc_pkg::ST_IDLE;
         end
         default: state_in = brsc_pkg::ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      cmd           = '0;
      amt_latch     = 1'b0;
      proc_in       = proc_ff;
      scan_in       = scan_ff;
      eval_valid_in = 1'b0;
      eval_idx_in   = scan_ff;
      done_in       = done_ff;
      count_in      = count_ff;
      progress_in   = progress_ff;
      seq_we        = 1'b0;
      status_in     = status_ff;
      granted_in    = granted_ff;
      out_idx_in    = out_idx_ff;
      case (state_ff)
         brsc_pkg::ST_IDLE: begin
            if (req_accept) begin
               proc_in   = req_process;
               amt_latch = 1'b1;
               case (req_type)
                  brsc_pkg::REQ_LOAD_ALLOC: cmd.load_alloc = in_range;
                  brsc_pkg::REQ_LOAD_MAX:   cmd.load_max   = in_range;
                  brsc_pkg::REQ_LOAD_AVAIL: cmd.load_avail = 1'b1;
                  brsc_pkg::REQ_REQUEST: begin
                     status_in  = brsc_pkg::STATUS_INVALID;
                     granted_in = 1'b0;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         brsc_pkg::ST_CHECK: begin
            if (!check.any_bad) begin
               cmd.apply   = 1'b1;
               scan_in     = '0;
               done_in     = '0;
               count_in    = '0;
               progress_in = 1'b0;
            end
         end
         brsc_pkg::ST_SCAN: begin
            eval_valid_in = (state_in == brsc_pkg::ST_SCAN);
            scan_in = ((7'(scan_ff) + 7'd1) == 7'(n_eff)) ? '0 : scan_ff + 1'b1;
            if (eval_fit) begin
               done_in[eval_idx_ff] = 1'b1;
               seq_we       = 1'b1;
               cmd.add_work = 1'b1;
            end
            count_in    = cnt_next;
            progress_in = prog_next;
            if (pass_end) begin
               if (all_done) begin
                  status_in  = brsc_pkg::STATUS_GRANT;
                  granted_in = 1'b1;
                  out_idx_in = '0;
               end else if (!prog_next) begin
                  cmd.rollback = 1'b1;
                  status_in    = brsc_pkg::STATUS_UNSAFE;
                  granted_in   = 1'b0;
               end else begin
                  progress_in = 1'b0;
               end
            end
         end
         brsc_pkg::ST_EMIT: begin
            if (!rsp_stall && !out_last) out_idx_in = out_idx_ff + 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= brsc_pkg::ST_IDLE;
         eval_valid_ff <= 1'b0;
         done_ff       <= '0;
         count_ff      <= '0;
         progress_ff   <= 1'b0;
         granted_ff    <= 1'b0;
         out_idx_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         eval_valid_ff <= eval_valid_in;
         done_ff       <= done_in;
         count_ff      <= count_in;
         progress_ff   <= progress_in;
         granted_ff    <= granted_in;
         out_idx_ff    <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_ff     <= proc_in;
      scan_ff     <= scan_in;
      eval_idx_ff <= eval_idx_in;
      status_ff   <= status_in;
      if (seq_we) seq_ff[count_ff[SEQ_W-1:0]] <= 4'(eval_idx_ff);
      for (int j = 0; j < NUM_LANES; j++) begin
         if (amt_latch) amt_ff[j] <= UNIT_BITS'(amt_port[j]);
      end
   end

   for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
      brsc_lane #(
         .MAX_PROCS (MAX_PROCS),
         .UNIT_BITS (UNIT_BITS),
         .WORK_W    (WORK_W)
      ) u_lane (
         .clock     (clock),
         .cmd       (cmd),
         .wr_addr   (wr_addr),
         .rd_addr   (rd_addr),
         .load_data (UNIT_BITS'(amt_port[j])),
         .amount    (amt_ff[j]),
         .active    (3'(j) < r_eff),
         .flags     (flags[j])
      );
   end

   brsc_merge #(
      .LANES (NUM_LANES)
   ) u_merge (
      .flags (flags),
      .check (check)
   );

   assign rsp_valid       = (state_ff == brsc_pkg::ST_EMIT);
   assign rsp_status      = status_ff;
   assign rsp_seq_process = granted_ff ? seq_ff[out_idx_ff] : 4'd0;
   assign rsp_seq_valid   = granted_ff;
   assign rsp_last        = out_last;

   `BRSC_ASSERT_NOW(a_done_count, clock, reset, state_ff == brsc_pkg::ST_SCAN, $countones(done_ff) == int'(count_ff), "finished set and count disagree")
   `BRSC_ASSERT_NOW(a_eval_in_scan, clock, reset, eval_valid_ff, state_ff == brsc_pkg::ST_SCAN, "evaluation outside scan")
   `BRSC_ASSERT_NOW(a_single_beat, clock, reset, rsp_valid && rsp_status != brsc_pkg::STATUS_GRANT, rsp_last && !rsp_seq_valid, "denied result not a single beat")
   `BRSC_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_valid && rsp_last && !rsp_stall, !rsp_valid && !req_stall, "block not idle after final beat")

endmodule

`default_nettype wire

/* test/banker_request_safety_check_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// banker_request_safety_check_top_tb
// Self-checking bench for the banker request safety check block.
// A shadow copy of the allocation, maximum and available tables predicts the
// verdict of each request: invalid, unsafe with rollback, or granted with the
// safe sequence. Every table entry is loaded before the first request. A
// short table of directed beats comes first. Its obvious verdicts are typed
// in and the rest go through the predictor. Random phases follow under
// several process and lane limits, including out-of-range ones, with
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module banker_request_safety_check_top_tb;

   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_BEATS   = 38;

   typedef struct packed {
      logic [1:0]      kind;
      logic [3:0]      proc;
      logic [0:3][7:0] amt;
   } req_beat_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] seq_process;
      logic       seq_valid;
      logic       last;
   } rsp_beat_type;

   typedef struct packed {
      req_beat_type beat;
      logic         typed;
      logic [1:0]   status;
   } dir_row_type;

   logic       clock;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic       req_stall;
   logic [1:0] req_type     = brsc_pkg::REQ_LOAD_AVAIL;
   logic [3:0] req_process  = 4'd0;
   logic [7:0] req_amount_0 = 8'd0;
   logic [7:0] req_amount_1 = 8'd0;
   logic [7:0] req_amount_2 = 8'd0;
   logic [7:0] req_amount_3 = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall    = 1'b0;
   logic [1:0] rsp_status;
   logic [3:0] rsp_seq_process;
   logic       rsp_seq_valid;
   logic       rsp_last;
   logic       csr_we       = 1'b0;
   logic       csr_index    = brsc_pkg::CSR_ACTIVE_PROCS;
   logic [4:0] csr_wdata    = 5'd0;

   logic [7:0] held_units [16][4];
   logic [7:0] max_claim  [16][4];
   logic [7:0] free_units [4];
   logic [4:0] procs_reg = 5'd16;
   logic [2:0] lanes_reg = 3'd4;

   rsp_beat_type verdict_q [$];
   rsp_beat_type fresh_q [$];
   int           fail_count = 0;
   int           idle_pct   = 0;
   int           stall_pct  = 0;

   int phase_procs [8] = '{16, 1, 0, 31, 5, 16, 8, 16};
   int phase_lanes [8] = '{4, 1, 0, 7, 2, 3, 4, 4};
   int phase_idle  [8] = '{0, 53, 0, 20, 0, 53, 0, 20};
   int phase_stall [8] = '{0, 0, 53, 20, 0, 0, 53, 20};

   dir_row_type directed_rows [25] = '{
      '{'{brsc_pkg::REQ_LOAD_AVAIL, 4'd0, {8'd10, 8'd10, 8'd10, 8'd10}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_ALLOC, 4'd0, {8'd1, 8'd0, 8'd0, 8'd0}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_MAX, 4'd0, {8'd5, 8'd5, 8'd5, 8'd5}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_ALLOC, 4'd1, {8'd0, 8'd0, 8'd0, 8'd0}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_MAX, 4'd1, {8'd3, 8'd3, 8'd3, 8'd255}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_ALLOC, 4'd2, {8'd0, 8'd0, 8'd0, 8'd0}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_MAX, 4'd2, {8'd0, 8'd0, 8'd0, 8'd0}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_ALLOC, 4'd3, {8'd2, 8'd2, 8'd2, 8'd2}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_MAX, 4'd3, {8'd1, 8'd1, 8'd1, 8'd1}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_REQUEST, 4'd15, {8'd0, 8'd0, 8'd0, 8'd0}},
        1'b1, brsc_pkg::STATUS_INVALID},
      '{'{brsc_pkg::REQ_REQUEST, 4'd0, {8'd5, 8'd0, 8'd0, 8'd0}},
        1'b1, brsc_pkg::STATUS_INVALID},
      '{'{brsc_pkg::REQ_REQUEST, 4'd1, {8'd0, 8'd0, 8'd0, 8'd11}},
        1'b1, brsc_pkg::STATUS_INVALID},
      '{'{brsc_pkg::REQ_REQUEST, 4'd3, {8'd0, 8'd0, 8'd0, 8'd0}},
        1'b1, brsc_pkg::STATUS_INVALID},
      '{'{brsc_pkg::REQ_REQUEST, 4'd2, {8'd0, 8'd0, 8'd0, 8'd0}},
        1'b1, brsc_pkg::STATUS_UNSAFE},
      '{'{brsc_pkg::REQ_LOAD_MAX, 4'd1, {8'd3, 8'd3, 8'd3, 8'd3}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_REQUEST, 4'd0, {8'd0, 8'd0, 8'd0, 8'd0}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_REQUEST, 4'd0, {8'd4, 8'd5, 8'd5, 8'd5}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_AVAIL, 4'd0, {8'd255, 8'd255, 8'd255, 8'd255}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_MAX, 4'd2, {8'd255, 8'd255, 8'd255, 8'd255}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_REQUEST, 4'd2, {8'd255, 8'd255, 8'd255, 8'd255}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_AVAIL, 4'd0, {8'd0, 8'd0, 8'd0, 8'd0}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_REQUEST, 4'd1, {8'd1, 8'd0, 8'd0, 8'd0}},
        1'b1, brsc_pkg::STATUS_INVALID},
      '{'{brsc_pkg::REQ_REQUEST, 4'd1, {8'd0, 8'd0, 8'd0, 8'd0}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_ALLOC, 4'd15, {8'd255, 8'd255, 8'd255, 8'd255}},
        1'b0, brsc_pkg::STATUS_GRANT},
      '{'{brsc_pkg::REQ_LOAD_MAX, 4'd15, {8'd255, 8'd255, 8'd255, 8'd255}},
        1'b0, brsc_pkg::STATUS_GRANT}
   };

   banker_request_safety_check_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_process     (req_process),
      .req_amount_0    (req_amount_0),
      .req_amount_1    (req_amount_1),
      .req_amount_2    (req_amount_2),
      .req_amount_3    (req_amount_3),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_seq_process (rsp_seq_process),
      .rsp_seq_valid   (rsp_seq_valid),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Verification failed");
      $finish;
   end

   function automatic int live_procs();
      if (procs_reg == 5'd0) return 1;
      if (procs_reg > 5'd16) return 16;
      return int'(procs_reg);
   endfunction

   function automatic int live_lanes();
      if (lanes_reg == 3'd0) return 1;
      if (lanes_reg > 3'd4) return 4;
      return int'(lanes_reg);
   endfunction

   function automatic void add_fresh(input rsp_beat_type v);
      fresh_q.insert(fresh_q.size(), v);
   endfunction

   function automatic void add_verdict(input rsp_beat_type v);
      verdict_q.insert(verdict_q.size(), v);
   endfunction

   function automatic void judge_beat(input req_beat_type b);
      int n, r, nd, cnt;
      int work [4];
      int order [16];
      bit done [16];
      bit moved, fits;
      fresh_q.delete();
      case (b.kind)
         brsc_pkg::REQ_LOAD_ALLOC: begin
            for (int j = 0; j < 4; j++) held_units[b.proc][j] = b.amt[j];
            return;
         end
         brsc_pkg::REQ_LOAD_MAX: begin
            for (int j = 0; j < 4; j++) max_claim[b.proc][j] = b.amt[j];
            return;
         end
         brsc_pkg::REQ_LOAD_AVAIL: begin
            for (int j = 0; j < 4; j++) free_units[j] = b.amt[j];
            return;
         end
         default: ;
      endcase
      n = live_procs();
      r = live_lanes();
      if (int'(b.proc) >= n) begin
         add_fresh(rsp_beat_type'{brsc_pkg::STATUS_INVALID, 4'd0, 1'b0, 1'b1});
         return;
      end
      for (int j = 0; j < r; j++) begin
         nd = int'(max_claim[b.proc][j]) - int'(held_units[b.proc][j]);
         if (int'(b.amt[j]) > nd || b.amt[j] > free_units[j]) begin
            add_fresh(rsp_beat_type'{brsc_pkg::STATUS_INVALID, 4'd0, 1'b0, 1'b1});
            return;
         end
      end
      for (int j = 0; j < r; j++) begin
         held_units[b.proc][j] = held_units[b.proc][j] + b.amt[j];
         free_units[j] = free_units[j] - b.amt[j];
      end
      for (int j = 0; j < 4; j++) work[j] = int'(free_units[j]);
      for (int i = 0; i < 16; i++) done[i] = 1'b0;
      cnt = 0;
      moved = 1'b1;
      while (cnt < n && moved) begin
         moved = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (!done[i]) begin
               fits = 1'b1;
               for (int j = 0; j < r; j++) begin
                  nd = int'(max_claim[i][j]) - int'(held_units[i][j]);
                  if (nd > work[j]) fits = 1'b0;
               end
               if (fits) begin
                  done[i] = 1'b1;
                  moved = 1'b1;
                  order[cnt] = i;
                  cnt++;
                  for (int j = 0; j < r; j++) work[j] += int'(held_units[i][j]);
               end
            end
         end
      end
      if (cnt < n) begin
         for (int j = 0; j < r; j++) begin
            held_units[b.proc][j] = held_units[b.proc][j] - b.amt[j];
            free_units[j] = free_units[j] + b.amt[j];
         end
         add_fresh(rsp_beat_type'{brsc_pkg::STATUS_UNSAFE, 4'd0, 1'b0, 1'b1});
         return;
      end
      for (int k = 0; k < n; k++)
         add_fresh(rsp_beat_type'{brsc_pkg::STATUS_GRANT, 4'(order[k]), 1'b1,
                                  k == n - 1});
   endfunction

   function automatic req_beat_type make_beat();
      req_beat_type b;
      int n, pick, nd, room;
      n = live_procs();
      pick = $urandom_range(99);
      b.kind = 2'($urandom_range(3));
      b.proc = 4'($urandom_range(15));
      for (int j = 0; j < 4; j++) b.amt[j] = 8'($urandom_range(255));
      if ($urandom_range(5) == 0) return b;
      if (pick < 10) begin
         b.kind = brsc_pkg::REQ_LOAD_MAX;
         for (int j = 0; j < 4; j++) begin
            room = int'(held_units[b.proc][j]) + $urandom_range(40);
            b.amt[j] = 8'((room > 255) ? 255 : room);
         end
      end else if (pick < 20) begin
         b.kind = brsc_pkg::REQ_LOAD_ALLOC;
         for (int j = 0; j < 4; j++) b.amt[j] = 8'($urandom_range(max_claim[b.proc][j]));
      end else if (pick < 28) begin
         b.kind = brsc_pkg::REQ_LOAD_AVAIL;
         for (int j = 0; j < 4; j++) b.amt[j] = 8'($urandom_range(255, 80));
      end else begin
         b.kind = brsc_pkg::REQ_REQUEST;
         b.proc = 4'($urandom_range(n - 1));
         for (int j = 0; j < live_lanes(); j++) begin
            nd = int'(max_claim[b.proc][j]) - int'(held_units[b.proc][j]);
            room = (nd < int'(free_units[j])) ? nd : int'(free_units[j]);
            if (room < 0) room = 0;
            b.amt[j] = 8'($urandom_range(room));
         end
      end
      return b;
   endfunction

   task automatic send_beat(input req_beat_type b, input logic typed,
                            input logic [1:0] status);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= b.kind;
      req_process  <= b.proc;
      req_amount_0 <= b.amt[0];
      req_amount_1 <= b.amt[1];
      req_amount_2 <= b.amt[2];
      req_amount_3 <= b.amt[3];
      do @(posedge clock); while (req_stall);
      judge_beat(b);
      if (typed)
         add_verdict(rsp_beat_type'{status, 4'd0, 1'b0, 1'b1});
      else
         foreach (fresh_q[k]) add_verdict(fresh_q[k]);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limits(input int procs, input int lanes);
      csr_we    <= 1'b1;
      csr_index <= brsc_pkg::CSR_ACTIVE_PROCS;
      csr_wdata <= 5'(procs);
      @(posedge clock);
      procs_reg = 5'(procs);
      csr_index <= brsc_pkg::CSR_ACTIVE_RES;
      csr_wdata <= 5'(lanes);
      @(posedge clock);
      lanes_reg = 3'(lanes);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : rsp_check
      rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("unexpected result beat: status %0d seq_process %0d", rsp_status,
                   rsp_seq_process);
            fail_count++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_seq_process !== want.seq_process) begin
               $error("seq_process: expected %0d, got %0d", want.seq_process,
                      rsp_seq_process);
               fail_count++;
            end
            if (rsp_seq_valid !== want.seq_valid) begin
               $error("seq_valid: expected %0d, got %0d", want.seq_valid, rsp_seq_valid);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      req_beat_type b;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every table entry before any request reads one
      for (int p = 0; p < 16; p++) begin
         b.kind = brsc_pkg::REQ_LOAD_MAX;
         b.proc = 4'(p);
         for (int j = 0; j < 4; j++) b.amt[j] = 8'($urandom_range(60));
         send_beat(b, 1'b0, brsc_pkg::STATUS_GRANT);
         b.kind = brsc_pkg::REQ_LOAD_ALLOC;
         for (int j = 0; j < 4; j++) b.amt[j] = 8'($urandom_range(b.amt[j]));
         send_beat(b, 1'b0, brsc_pkg::STATUS_GRANT);
      end
      b.kind = brsc_pkg::REQ_LOAD_AVAIL;
      for (int j = 0; j < 4; j++) b.amt[j] = 8'($urandom_range(255, 200));
      send_beat(b, 1'b0, brsc_pkg::STATUS_GRANT);
      settle();

      set_limits(4, 4);
      foreach (directed_rows[k])
         send_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].status);
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         set_limits(phase_procs[ph], phase_lanes[ph]);
         idle_pct  = phase_idle[ph];
         stall_pct = phase_stall[ph];
         repeat (PHASE_BEATS) send_beat(make_beat(), 1'b0, brsc_pkg::STATUS_GRANT);
         settle();
      end

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/brsc_pkg.sv
hdl/brsc_lane.sv
hdl/brsc_merge.sv
hdl/banker_request_safety_check_top.sv
test/banker_request_safety_check_top_tb.sv
